// File: rtl/core/fccm_pkg.sv
`timescale 1ns / 1ps
package fccm_pkg;

	localparam int FAT_TABLE_BYTES_DEF = 131072;
	localparam int SECTOR_BYTES_DEF    = 512;
	localparam int RESULT_DEPTH        = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [31:0] FAT12_LIMIT     = 32'd4085;
	localparam logic [31:0] FAT16_LIMIT     = 32'd65525;
	localparam logic [15:0] FAT12_MASK      = 16'h0FFF;
	localparam logic [15:0] FAT12_END       = 16'h0FF8;
	localparam logic [15:0] FAT16_END       = 16'hFFF8;
	localparam int          DIR_ENTRY_BYTES = 32;

	// register defaults after reset
	localparam logic [27:0] PARTITION_OFFSET_RST    = 28'd0;
	localparam logic [15:0] RESERVED_SECTORS_RST    = 16'd1;
	localparam logic [2:0]  FAT_COPIES_RST          = 3'd2;
	localparam logic [8:0]  SECTORS_PER_FAT_RST     = 9'd9;
	localparam logic [15:0] ROOT_ENTRIES_RST        = 16'd224;
	localparam logic [31:0] TOTAL_SECTORS_RST       = 32'd2880;
	localparam logic [7:0]  SECTORS_PER_CLUSTER_RST = 8'd1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PARTITION_OFFSET    = 3'd0,
		REG_RESERVED_SECTORS    = 3'd1,
		REG_FAT_COPIES          = 3'd2,
		REG_SECTORS_PER_FAT     = 3'd3,
		REG_ROOT_ENTRIES        = 3'd4,
		REG_TOTAL_SECTORS       = 3'd5,
		REG_SECTORS_PER_CLUSTER = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_DATA        = 2'd0,
		ST_END         = 2'd1,
		ST_FAT32       = 2'd2,
		ST_LOW_CLUSTER = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] data_start;
		logic [7:0]  spc;
		logic        is12;
		logic        is32;
	} geom_t;

	typedef struct packed {
		logic [31:0] sector_lba;
		logic [15:0] next_cluster;
		status_t     status;
	} result_t;

endpackage

// File: rtl/core/fccm_ram.sv
`timescale 1ns / 1ps
module fccm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/fccm_geometry.sv
`timescale 1ns / 1ps
module fccm_geometry #(
	parameter int SECTOR_BYTES = fccm_pkg::SECTOR_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fccm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fccm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fccm_pkg::geom_t                  geom
);

	localparam int SB_LOG   = $clog2(SECTOR_BYTES);
	localparam int NUM_W    = 22;
	localparam int RS_SHIFT = NUM_W + SB_LOG;
	localparam int MULT_W   = 23;
	localparam int ROOT_W   = MULT_W - SB_LOG;
	localparam longint unsigned RS_MULT =
		((64'd1 << RS_SHIFT) + SECTOR_BYTES - 1) / SECTOR_BYTES;

	localparam int RST_FAT_START = int'(fccm_pkg::PARTITION_OFFSET_RST)
		+ int'(fccm_pkg::RESERVED_SECTORS_RST);
	localparam int RST_FAT_AREA = int'(fccm_pkg::FAT_COPIES_RST)
		* int'(fccm_pkg::SECTORS_PER_FAT_RST);
	localparam int RST_ROOT_SIZE = (int'(fccm_pkg::ROOT_ENTRIES_RST)
		* fccm_pkg::DIR_ENTRY_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES;
	localparam int RST_DATA_START = RST_FAT_START + RST_FAT_AREA + RST_ROOT_SIZE;

	logic [27:0] partition_offset_q;
	logic [15:0] reserved_sectors_q;
	logic [2:0]  fat_copies_q;
	logic [8:0]  sectors_per_fat_q;
	logic [15:0] root_entries_q;
	logic [31:0] total_sectors_q;
	logic [7:0]  sectors_per_cluster_q;

	logic [31:0]         fat_start_q;
	logic [11:0]         fat_area_q;
	logic [ROOT_W-1:0]   root_size_q;
	logic                is12_q;
	logic                is32_q;
	logic [31:0]         data_start_q;

	logic [NUM_W-1:0]        root_bytes;
	logic [NUM_W+MULT_W-1:0] root_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partition_offset_q    <= fccm_pkg::PARTITION_OFFSET_RST;
			reserved_sectors_q    <= fccm_pkg::RESERVED_SECTORS_RST;
			fat_copies_q          <= fccm_pkg::FAT_COPIES_RST;
			sectors_per_fat_q     <= fccm_pkg::SECTORS_PER_FAT_RST;
			root_entries_q        <= fccm_pkg::ROOT_ENTRIES_RST;
			total_sectors_q       <= fccm_pkg::TOTAL_SECTORS_RST;
			sectors_per_cluster_q <= fccm_pkg::SECTORS_PER_CLUSTER_RST;
		end else if (cfg_we) begin
			unique case (fccm_pkg::cfg_reg_t'(cfg_index))
				fccm_pkg::REG_PARTITION_OFFSET:    partition_offset_q <= cfg_data[27:0];
				fccm_pkg::REG_RESERVED_SECTORS:    reserved_sectors_q <= cfg_data[15:0];
				fccm_pkg::REG_FAT_COPIES:          fat_copies_q <= cfg_data[2:0];
				fccm_pkg::REG_SECTORS_PER_FAT:     sectors_per_fat_q <= cfg_data[8:0];
				fccm_pkg::REG_ROOT_ENTRIES:        root_entries_q <= cfg_data[15:0];
				fccm_pkg::REG_TOTAL_SECTORS:       total_sectors_q <= cfg_data;
				fccm_pkg::REG_SECTORS_PER_CLUSTER: sectors_per_cluster_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ceil(entries * 32 / sector size) by reciprocal multiply; exact over the 22-bit range
	assign root_bytes = {1'b0, root_entries_q, 5'b0} + NUM_W'(SECTOR_BYTES - 1);
	assign root_prod  = {{MULT_W{1'b0}}, root_bytes} * (NUM_W+MULT_W)'(RS_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_start_q  <= 32'(RST_FAT_START);
			fat_area_q   <= 12'(RST_FAT_AREA);
			root_size_q  <= ROOT_W'(RST_ROOT_SIZE);
			is12_q       <= 1'b1;
			is32_q       <= 1'b0;
			data_start_q <= 32'(RST_DATA_START);
		end else begin
			fat_start_q  <= 32'(partition_offset_q) + 32'(reserved_sectors_q);
			fat_area_q   <= 12'(fat_copies_q) * 12'(sectors_per_fat_q);
			root_size_q  <= root_prod[RS_SHIFT +: ROOT_W];
			is12_q       <= total_sectors_q < fccm_pkg::FAT12_LIMIT;
			is32_q       <= total_sectors_q >= fccm_pkg::FAT16_LIMIT;
			data_start_q <= fat_start_q + 32'(fat_area_q) + 32'(root_size_q);
		end
	end

	assign geom.data_start = data_start_q;
	assign geom.spc        = sectors_per_cluster_q;
	assign geom.is12       = is12_q;
	assign geom.is32       = is32_q;

endmodule

// File: rtl/core/fccm_lookup.sv
`timescale 1ns / 1ps
module fccm_lookup #(
	parameter int FAT_TABLE_BYTES = fccm_pkg::FAT_TABLE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              mode,
	input  logic [16:0]       table_address,
	input  logic [7:0]        table_byte,
	input  logic [15:0]       cluster,
	input  fccm_pkg::geom_t   geom,
	output logic              res_valid,
	output fccm_pkg::result_t res,
	output logic [1:0]        inflight
);

	localparam int AW = $clog2(FAT_TABLE_BYTES);

	logic        valid_s1;
	logic        mode_s1;
	logic [16:0] addr_s1;
	logic [7:0]  byte_s1;
	logic [15:0] clus_s1;

	logic                valid_s2;
	fccm_pkg::status_t   status_s2;
	logic                odd_s2;
	logic                is12_s2;
	logic [23:0]         prod_s2;

	fccm_pkg::status_t status;
	logic [17:0]       byte_addr;
	logic [AW-1:0]     lo_addr;
	logic [AW-1:0]     hi_addr;
	logic              wr_en;
	logic              rd_en;
	logic [7:0]        lo_byte;
	logic [7:0]        hi_byte;
	logic [15:0]       word;
	logic [15:0]       next;
	logic [15:0]       end_mark;

	// wrap a byte address into the store by repeated compare and subtract
	function automatic logic [AW-1:0] fold(input logic [17:0] v);
		logic [25:0] r;
		logic [25:0] step;
		r = 26'(v);
		for (int k = 7; k >= 0; k--) begin
			step = 26'(FAT_TABLE_BYTES) << k;
			if (r >= step) begin
				r = r - step;
			end
		end
		return r[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1 && mode_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			addr_s1 <= table_address;
			byte_s1 <= table_byte;
			clus_s1 <= cluster;
		end
	end

	assign end_mark = geom.is12 ? fccm_pkg::FAT12_END : fccm_pkg::FAT16_END;

	always_comb begin
		if (geom.is32) begin
			status = fccm_pkg::ST_FAT32;
		end else if (clus_s1 < 16'd2) begin
			status = fccm_pkg::ST_LOW_CLUSTER;
		end else if (clus_s1 >= end_mark) begin
			status = fccm_pkg::ST_END;
		end else begin
			status = fccm_pkg::ST_DATA;
		end
	end

	// FAT12 entry starts at cluster*3/2, FAT16 at cluster*2
	assign byte_addr = geom.is12 ? ((18'(clus_s1) + {1'b0, clus_s1, 1'b0}) >> 1)
		: {1'b0, clus_s1, 1'b0};
	assign lo_addr = fold(byte_addr);
	assign hi_addr = fold(byte_addr + 18'd1);

	assign wr_en = valid_s1 && !mode_s1 && ({1'b0, addr_s1} < 18'(FAT_TABLE_BYTES));
	assign rd_en = valid_s1 && mode_s1;

	// two copies of the table give both bytes of an entry in one read
	fccm_ram #(
		.WIDTH(8),
		.DEPTH(FAT_TABLE_BYTES)
	) u_ram_lo (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1[AW-1:0]),
		.wdata (byte_s1),
		.re    (rd_en),
		.raddr (lo_addr),
		.rdata (lo_byte)
	);

	fccm_ram #(
		.WIDTH(8),
		.DEPTH(FAT_TABLE_BYTES)
	) u_ram_hi (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1[AW-1:0]),
		.wdata (byte_s1),
		.re    (rd_en),
		.raddr (hi_addr),
		.rdata (hi_byte)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			status_s2 <= status;
			odd_s2    <= clus_s1[0];
			is12_s2   <= geom.is12;
			prod_s2   <= (24'(clus_s1) - 24'd2) * 24'(geom.spc);
		end
	end

	assign word = {hi_byte, lo_byte};

	always_comb begin
		if (!is12_s2) begin
			next = word;
		end else if (odd_s2) begin
			next = {4'b0, word[15:4]} & fccm_pkg::FAT12_MASK;
		end else begin
			next = word & fccm_pkg::FAT12_MASK;
		end
	end

	assign res_valid = valid_s2;

	always_comb begin
		res.status = status_s2;
		if (status_s2 == fccm_pkg::ST_DATA) begin
			res.sector_lba   = geom.data_start + 32'(prod_s2);
			res.next_cluster = next;
		end else begin
			res.sector_lba   = '0;
			res.next_cluster = '0;
		end
	end

	assign inflight = 2'(valid_s1 && mode_s1) + 2'(valid_s2);

endmodule

// File: rtl/core/fccm_result_fifo.sv
`timescale 1ns / 1ps
module fccm_result_fifo #(
	parameter int DEPTH = fccm_pkg::RESULT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  fccm_pkg::result_t          push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output fccm_pkg::result_t          head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	fccm_pkg::result_t entry_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];
	assign count      = count_q;

endmodule

// File: rtl/core/fat_cluster_chain_mapper.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle when in_ready is high, writes and lookups mixed; a lookup
// passes the input register and the FAT store read into the result queue. Two copies of the
// FAT byte store, each with one read port, give both bytes of an entry in a single read.
// A four-entry result queue holds finished results; input is refused once the queued
// results and the lookups still in the pipeline add up to four.
// Reset restores the boot-sector register defaults and empties the pipeline and queue;
// the FAT store is not cleared and holds nothing meaningful until written.
module fat_cluster_chain_mapper #(
	parameter int FAT_TABLE_BYTES = fccm_pkg::FAT_TABLE_BYTES_DEF,
	parameter int SECTOR_BYTES    = fccm_pkg::SECTOR_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fccm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fccm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [16:0]                      table_address,
	input  logic [7:0]                       table_byte,
	input  logic [15:0]                      cluster,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [31:0]                      sector_lba,
	output logic [15:0]                      next_cluster,
	output logic [1:0]                       status
);

	localparam int CW = $clog2(fccm_pkg::RESULT_DEPTH + 1);

	fccm_pkg::geom_t   geom;
	fccm_pkg::result_t res;
	fccm_pkg::result_t head;
	logic              res_valid;
	logic [1:0]        inflight;
	logic [CW-1:0]     queued;
	logic              take;

	// count every result still to arrive so the queue can never overflow
	assign in_ready = (CW'(inflight) + queued) < CW'(fccm_pkg::RESULT_DEPTH);
	assign take     = in_valid && in_ready;

	fccm_geometry #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_geometry (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	fccm_lookup #(
		.FAT_TABLE_BYTES(FAT_TABLE_BYTES)
	) u_lookup (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.mode          (mode),
		.table_address (table_address),
		.table_byte    (table_byte),
		.cluster       (cluster),
		.geom          (geom),
		.res_valid     (res_valid),
		.res           (res),
		.inflight      (inflight)
	);

	fccm_result_fifo #(
		.DEPTH(fccm_pkg::RESULT_DEPTH)
	) u_result_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.pop        (out_ready),
		.head_valid (out_valid),
		.head       (head),
		.count      (queued)
	);

	assign sector_lba   = head.sector_lba;
	assign next_cluster = head.next_cluster;
	assign status       = head.status;

endmodule
